[rtl/core/eemi_pkg.sv]
`timescale 1ns / 1ps

package eemi_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int COEFF_WIDTH   = OPERAND_WIDTH + 1;
  localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take new operands, seed the recurrence
    logic div_init;  // prepare a division of prev_r by cur_r
    logic div_step;  // one quotient bit
    logic update;    // shift the remainder and coefficient pairs
    logic finish;    // latch the result registers
  } dp_cmd_t;

  typedef struct packed {
    logic cur_r_zero;
  } dp_sts_t;

endpackage

[rtl/core/eemi_ctrl.sv]
`timescale 1ns / 1ps

module eemi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output eemi_pkg::dp_cmd_t  cmd,
  input  eemi_pkg::dp_sts_t  sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE
  } state_t;

  state_t                           state_r;
  logic [eemi_pkg::CNT_WIDTH-1:0]   cnt_r;
  logic                             out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt_r <= '0;
          if (sts.cur_r_zero) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == eemi_pkg::CNT_WIDTH'(eemi_pkg::OPERAND_WIDTH - 1)) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state_r <= ST_CHECK;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && start;
    cmd.div_init = (state_r == ST_CHECK) && !sts.cur_r_zero;
    cmd.finish   = (state_r == ST_CHECK) && sts.cur_r_zero;
    cmd.div_step = (state_r == ST_DIV);
    cmd.update   = (state_r == ST_UPDATE);
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/eemi_datapath.sv]
`timescale 1ns / 1ps

module eemi_datapath (
  input  logic                                     clk,
  input  eemi_pkg::dp_cmd_t                        cmd,
  output eemi_pkg::dp_sts_t                        sts,
  input  logic        [eemi_pkg::OPERAND_WIDTH-1:0] a_value,
  input  logic        [eemi_pkg::OPERAND_WIDTH-1:0] modulus,
  output logic        [eemi_pkg::OPERAND_WIDTH-1:0] gcd_value,
  output logic signed [eemi_pkg::COEFF_WIDTH-1:0]   coeff_a,
  output logic signed [eemi_pkg::COEFF_WIDTH-1:0]   coeff_b,
  output logic        [eemi_pkg::OPERAND_WIDTH-1:0] inverse
);

  localparam int W  = eemi_pkg::OPERAND_WIDTH;
  localparam int CW = eemi_pkg::COEFF_WIDTH;

  logic [W-1:0]  prev_r_r, cur_r_r, mod_r;
  logic [CW-1:0] prev_s_r, cur_s_r, prev_t_r, cur_t_r;
  logic [W-1:0]  rem_r, dvd_r;
  logic [CW-1:0] acc_s_r, acc_t_r;
  logic [W-1:0]  gcd_r, inv_r;
  logic [CW-1:0] ca_r, cb_r;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_nxt;
  logic [CW-1:0] acc_s_nxt, acc_t_nxt;
  logic [W-1:0]  inv_nxt;

  // restoring divider: one quotient bit per step, q*cur folded in by horner
  always_comb begin
    shifted   = {rem_r, dvd_r[W-1]};
    diff      = shifted - {1'b0, cur_r_r};
    ge        = (shifted >= {1'b0, cur_r_r});
    rem_nxt   = ge ? diff[W-1:0] : shifted[W-1:0];
    acc_s_nxt = {acc_s_r[CW-2:0], 1'b0} + (ge ? cur_s_r : '0);
    acc_t_nxt = {acc_t_r[CW-2:0], 1'b0} + (ge ? cur_t_r : '0);
    inv_nxt   = prev_s_r[CW-1] ? (prev_s_r[W-1:0] + mod_r) : prev_s_r[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_r_r <= a_value;
      cur_r_r  <= modulus;
      mod_r    <= modulus;
      prev_s_r <= CW'(1);
      cur_s_r  <= '0;
      prev_t_r <= '0;
      cur_t_r  <= CW'(1);
    end else if (cmd.update) begin
      prev_r_r <= cur_r_r;
      cur_r_r  <= rem_r;
      prev_s_r <= cur_s_r;
      cur_s_r  <= prev_s_r - acc_s_r;
      prev_t_r <= cur_t_r;
      cur_t_r  <= prev_t_r - acc_t_r;
    end

    if (cmd.div_init) begin
      rem_r   <= '0;
      dvd_r   <= prev_r_r;
      acc_s_r <= '0;
      acc_t_r <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= rem_nxt;
      dvd_r   <= {dvd_r[W-2:0], 1'b0};
      acc_s_r <= acc_s_nxt;
      acc_t_r <= acc_t_nxt;
    end

    if (cmd.finish) begin
      gcd_r <= prev_r_r;
      ca_r  <= prev_s_r;
      cb_r  <= prev_t_r;
      inv_r <= inv_nxt;
    end
  end

  assign sts.cur_r_zero = (cur_r_r == '0);
  assign gcd_value      = gcd_r;
  assign coeff_a        = $signed(ca_r);
  assign coeff_b        = $signed(cb_r);
  assign inverse        = inv_r;

endmodule

[rtl/core/extended_euclid_mod_inverse_core.sv]
`timescale 1ns / 1ps

// extended euclid core: gcd, bezout coefficients and inverse of a mod m
// input: present in_a_value and in_modulus with start; the transfer happens
//   at a clock edge where start is high and busy is low
// output: out_valid is high for exactly one cycle with out_gcd_value,
//   out_coeff_a, out_coeff_b and out_inverse; the receiver takes that
//   transfer at the edge ending the cycle and cannot hold it off, the
//   result registers keep their values until the next result
// sequence: from the input transfer the core runs k euclid iterations, k up
//   to 46 for 32-bit operands, then a final check that sets out_valid;
//   each iteration is a check state, one restoring division at one quotient
//   bit per cycle, and an update state
// throughput: one operation at a time; busy stays high until the cycle
//   of the strobe, and a new start may be given in that cycle
// inverse is only meaningful when out_gcd_value is one
// reset: synchronous rst_n returns the controller to idle and drops busy
//   and out_valid; nothing else needs clearing

module extended_euclid_mod_inverse_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic        [eemi_pkg::OPERAND_WIDTH-1:0] in_a_value,
  input  logic        [eemi_pkg::OPERAND_WIDTH-1:0] in_modulus,
  output logic                                     out_valid,
  output logic        [eemi_pkg::OPERAND_WIDTH-1:0] out_gcd_value,
  output logic signed [eemi_pkg::COEFF_WIDTH-1:0]   out_coeff_a,
  output logic signed [eemi_pkg::COEFF_WIDTH-1:0]   out_coeff_b,
  output logic        [eemi_pkg::OPERAND_WIDTH-1:0] out_inverse
);

  eemi_pkg::dp_cmd_t cmd;
  eemi_pkg::dp_sts_t sts;

  eemi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  eemi_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .a_value   (in_a_value),
    .modulus   (in_modulus),
    .gcd_value (out_gcd_value),
    .coeff_a   (out_coeff_a),
    .coeff_b   (out_coeff_b),
    .inverse   (out_inverse)
  );

endmodule
